/* rtl/core/permutation_test_tally_core_defines.svh */
// Assertion macros for the permutation test tally core.
`ifndef PERMUTATION_TEST_TALLY_CORE_DEFINES_SVH
`define PERMUTATION_TEST_TALLY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PTT_ASSERT_SAME(lbl, ante, cons)
`define PTT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/ptt_pkg.sv */
`timescale 1ns / 1ps
package ptt_pkg;
    localparam int MAX_STATS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 20;
    localparam int OUT_W          = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_STATS      = 3'd0,
        CFG_NUM_REPS       = 3'd1,
        CFG_ADAPTIVE_ON    = 3'd2,
        CFG_ADAPTIVE_MIN   = 3'd3,
        CFG_INTERVAL_BASE  = 3'd4,
        CFG_INTERVAL_SLOPE = 3'd5,
        CFG_Z_THRESHOLD    = 3'd6,
        CFG_ALPHA_LEVEL    = 3'd7
    } t_cfg_idx;

    localparam logic [4:0]  RST_NUM_STATS      = 5'd1;
    localparam logic [19:0] RST_NUM_REPS       = 20'd1000;
    localparam logic        RST_ADAPTIVE_ON    = 1'b0;
    localparam logic [19:0] RST_ADAPTIVE_MIN   = 20'd5;
    localparam logic [15:0] RST_INTERVAL_BASE  = 16'd1;
    localparam logic [15:0] RST_INTERVAL_SLOPE = 16'd655;
    localparam logic [15:0] RST_Z_THRESHOLD    = 16'd512;
    localparam logic [15:0] RST_ALPHA_LEVEL    = 16'd3277;
endpackage

/* rtl/core/permutation_test_tally_core.sv */
`timescale 1ns / 1ps
// Permutation test tally core.
// Input channel: i_valid with o_stall; one statistic value per transfer,
// tagged with its index. Output channel: o_valid with i_stall; exactly one
// result per input transfer, in order, held in an output register.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// the block is idle; the user must keep to this, as the block has no check for it.
// An ordinary item passes through accept and memory read, read-modify-write
// of the statistic's table entry, then result load. A round end in adaptive
// mode adds a bit-serial remainder of the round count by the check interval
// and then the gates; on a check round that passes the gates, the block
// reads each checked statistic's entry and takes it through stages A to F.
// Reset loads the configuration defaults and clears all tallies at once
// through per-entry valid bits; start_test does the same for the tallies.
// If the receiver stalls, the result waits in the output register and the
// block holds the next item's result until that register is free.
module permutation_test_tally_core
#(
    parameter int MAX_STATS  = ptt_pkg::MAX_STATS_DEF,
    parameter int COUNT_BITS = ptt_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [3:0]                       i_stat_index,
    input  logic signed [31:0]               i_score_value,
    input  logic                             i_score_valid,
    input  logic                             i_tie_coin,
    input  logic                             i_round_last,
    input  logic                             i_start_test,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [3:0]                       o_out_stat,
    output logic [ptt_pkg::OUT_W-1:0]        o_exceed_count,
    output logic [ptt_pkg::OUT_W-1:0]        o_best_tie_count,
    output logic [ptt_pkg::OUT_W-1:0]        o_invalid_count,
    output logic [ptt_pkg::OUT_W-1:0]        o_round_count,
    output logic                             o_orig_ok,
    output logic                             o_round_end,
    output logic                             o_more_to_do,
    input  logic                             i_cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ptt_pkg::*;

    localparam int IW = (MAX_STATS > 1) ? $clog2(MAX_STATS) : 1;
    localparam int CB = COUNT_BITS;
    localparam int RW = 32 + 1 + CB + 32 + CB + CB;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    typedef struct packed {
        logic signed [31:0] orig;
        logic               ov;
        logic [CB-1:0]      exc;
        logic signed [31:0] best;
        logic [CB-1:0]      tie;
        logic [CB-1:0]      inv;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_DIV, S_GATE, S_W_RD, S_W_A, S_W_B, S_W_C, S_W_D, S_W_E,
        S_W_F, S_FIN
    } t_state;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    logic [4:0]  r_num_stats;
    logic [19:0] r_num_reps;
    logic        r_adaptive_on;
    logic [19:0] r_adaptive_min;
    logic [15:0] r_interval_base;
    logic [15:0] r_interval_slope;
    logic [15:0] r_z_threshold;
    logic [15:0] r_alpha_level;

    t_state r_state;
    logic [19:0] r_rounds;
    logic [15:0] r_civ;
    logic        r_done;
    logic [MAX_STATS-1:0] r_ent_vld;

    logic [RW-1:0] r_mem [MAX_STATS];
    logic [RW-1:0] r_rdata;
    logic          r_rvld;
    logic [IW-1:0] rd_addr;

    logic [3:0]         r_idx;
    logic signed [31:0] r_val;
    logic               r_sv, r_coin, r_last;
    logic [CB-1:0]      r_t_exc, r_t_tie, r_t_inv;
    logic               r_t_ok;

    logic [19:0] r_dq;
    logic [16:0] r_rem;
    logic [15:0] r_div;
    logic [4:0]  r_dcnt;

    logic [IW-1:0] r_s;
    logic [4:0]    r_ns;
    logic [31:0]   r_zz;
    logic [20:0]   r_R, r_N;
    logic [36:0]   r_b, r_d;
    logic [39:0]   r_rn;
    logic [56:0]   r_dn;
    logic [51:0]   r_rz;
    logic [93:0]   r_lhs;
    logic [71:0]   r_rhs;

    logic in_acc, out_free, in_range;
    t_rec old_rec, new_rec;
    logic wr_en;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign in_range = (32'(r_idx) < MAX_STATS);
    assign old_rec  = r_rvld ? t_rec'(r_rdata) : '0;

    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = IW'(i_stat_index);
        end else begin
            rd_addr = r_s;
        end
    end

    always_comb begin
        new_rec = old_rec;
        wr_en   = 1'b0;
        if (in_range) begin
            if (r_rounds == '0) begin
                if (r_sv) begin
                    new_rec.orig = r_val;
                    new_rec.ov   = 1'b1;
                    wr_en        = 1'b1;
                end
            end else if (old_rec.ov) begin
                wr_en = 1'b1;
                if (r_sv) begin
                    if (r_val > old_rec.orig || (r_val == old_rec.orig && r_coin)) begin
                        new_rec.exc = sat_inc(old_rec.exc);
                    end
                    if (r_rounds == 20'd1 || r_val > old_rec.best) begin
                        new_rec.tie  = CB'(1);
                        new_rec.best = r_val;
                    end else if (r_val == old_rec.best) begin
                        new_rec.tie = sat_inc(old_rec.tie);
                    end
                end else begin
                    new_rec.exc = sat_inc(old_rec.exc);
                    new_rec.inv = sat_inc(old_rec.inv);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD && wr_en) begin
            r_mem[IW'(r_idx)] <= RW'(new_rec);
        end
        r_rdata <= r_mem[rd_addr];
        r_rvld  <= (in_acc && i_start_test) ? 1'b0 : r_ent_vld[rd_addr];
    end

    logic [16:0] div_try;
    logic [35:0] iv_prod;
    logic [20:0] iv_sum;
    logic [32:0] ext_w;
    logic [CB:0] rr_w;
    logic [4:0]  ns_w;

    assign div_try = {r_rem[15:0], r_dq[19]};
    assign iv_prod = r_rounds * r_interval_slope;
    assign iv_sum  = 21'(r_interval_base) + 21'(iv_prod[35:16]);
    assign rr_w    = {1'b0, old_rec.exc} + 1'b1;
    assign ext_w   = 33'(rr_w);
    assign ns_w    = (32'(r_num_stats) > MAX_STATS) ? 5'(MAX_STATS) : r_num_stats;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_stats      <= RST_NUM_STATS;
            r_num_reps       <= RST_NUM_REPS;
            r_adaptive_on    <= RST_ADAPTIVE_ON;
            r_adaptive_min   <= RST_ADAPTIVE_MIN;
            r_interval_base  <= RST_INTERVAL_BASE;
            r_interval_slope <= RST_INTERVAL_SLOPE;
            r_z_threshold    <= RST_Z_THRESHOLD;
            r_alpha_level    <= RST_ALPHA_LEVEL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_STATS:      r_num_stats      <= i_cfg_data[4:0];
                CFG_NUM_REPS:       r_num_reps       <= i_cfg_data[19:0];
                CFG_ADAPTIVE_ON:    r_adaptive_on    <= i_cfg_data[0];
                CFG_ADAPTIVE_MIN:   r_adaptive_min   <= i_cfg_data[19:0];
                CFG_INTERVAL_BASE:  r_interval_base  <= i_cfg_data[15:0];
                CFG_INTERVAL_SLOPE: r_interval_slope <= i_cfg_data[15:0];
                CFG_Z_THRESHOLD:    r_z_threshold    <= i_cfg_data[15:0];
                CFG_ALPHA_LEVEL:    r_alpha_level    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rounds  <= '0;
            r_civ     <= RST_INTERVAL_BASE;
            r_done    <= 1'b0;
            r_ent_vld <= '0;
            o_valid   <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_FIN) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx  <= i_stat_index;
                        r_val  <= i_score_value;
                        r_sv   <= i_score_valid;
                        r_coin <= i_tie_coin;
                        r_last <= i_round_last;
                        if (i_start_test) begin
                            r_ent_vld <= '0;
                            r_rounds  <= '0;
                            r_civ     <= r_interval_base;
                        end
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (wr_en) begin
                        r_ent_vld[IW'(r_idx)] <= 1'b1;
                    end
                    r_t_exc <= in_range ? new_rec.exc : '0;
                    r_t_tie <= in_range ? new_rec.tie : '0;
                    r_t_inv <= in_range ? new_rec.inv : '0;
                    r_t_ok  <= in_range ? new_rec.ov : 1'b0;
                    r_done  <= (r_rounds >= r_num_reps);
                    if (r_last && r_adaptive_on) begin
                        r_dq    <= r_rounds;
                        r_rem   <= '0;
                        r_div   <= (r_civ == '0) ? 16'd1 : r_civ;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    r_dq <= {r_dq[18:0], 1'b0};
                    r_rem <= (div_try >= 17'(r_div)) ? div_try - 17'(r_div) : div_try;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'd19) begin
                        r_state <= S_GATE;
                    end
                end
                S_GATE: begin
                    if (r_rem != '0 || r_rounds < r_adaptive_min) begin
                        r_done  <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_rounds > r_num_reps) begin
                        r_done  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_civ <= (iv_sum > 21'hFFFF) ? 16'hFFFF : iv_sum[15:0];
                        r_zz  <= r_z_threshold * r_z_threshold;
                        r_ns  <= ns_w;
                        r_s   <= '0;
                        if (ns_w == '0) begin
                            r_done  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_W_RD;
                        end
                    end
                end
                S_W_RD: begin
                    r_state <= S_W_A;
                end
                S_W_A: begin
                    r_R <= 21'(rr_w);
                    r_N <= {1'b0, r_rounds} + 1'b1;
                    r_b <= r_alpha_level * ({1'b0, r_rounds} + 21'd1);
                    if (old_rec.exc == '0 || ext_w > 33'(r_rounds) + 33'd1) begin
                        r_done  <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_W_B;
                    end
                end
                S_W_B: begin
                    r_d <= ({r_R, 16'b0} >= r_b) ? {r_R, 16'b0} - r_b : r_b - {r_R, 16'b0};
                    r_rn <= r_R * (r_N - r_R);
                    r_state <= S_W_C;
                end
                S_W_C: begin
                    r_dn <= r_d * r_rounds;
                    r_rz <= r_zz * r_rn[19:0];
                    r_state <= S_W_D;
                end
                S_W_D: begin
                    r_lhs <= r_d * r_dn[28:0];
                    r_rhs <= 72'(r_rz) + {{20'b0, r_zz} * {32'b0, r_rn[39:20]}, 20'b0};
                    r_state <= S_W_E;
                end
                S_W_E: begin
                    r_lhs <= r_lhs + {{28'b0, r_d} * {37'b0, r_dn[56:29]}, 29'b0};
                    r_state <= S_W_F;
                end
                S_W_F: begin
                    if (r_lhs <= {6'b0, r_rhs, 16'b0}) begin
                        r_done  <= 1'b0;
                        r_state <= S_FIN;
                    end else if (32'(r_s) + 32'd1 >= 32'(r_ns)) begin
                        r_done  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_s     <= r_s + 1'b1;
                        r_state <= S_W_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_valid          <= 1'b1;
                        o_out_stat       <= r_idx;
                        o_exceed_count   <= OUT_W'(r_t_exc);
                        o_best_tie_count <= OUT_W'(r_t_tie);
                        o_invalid_count  <= OUT_W'(r_t_inv);
                        o_orig_ok        <= r_t_ok;
                        o_round_end      <= r_last;
                        o_more_to_do     <= r_last && !r_done;
                        if (r_last && !r_done && r_rounds != 20'hFFFFF) begin
                            r_rounds      <= r_rounds + 1'b1;
                            o_round_count <= r_rounds + 1'b1;
                        end else begin
                            o_round_count <= r_rounds;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "permutation_test_tally_core_defines.svh"

    `PTT_ASSERT_NEXT(a_accept_to_upd, in_acc, r_state == S_UPD)
    `PTT_ASSERT_SAME(a_more_needs_end, o_valid, !o_more_to_do || o_round_end)
    `PTT_ASSERT_NEXT(a_more_counts, r_state == S_FIN && out_free && r_last && !r_done, r_rounds != '0)
    `PTT_ASSERT_SAME(a_walk_in_range, r_state == S_W_RD, 32'(r_s) < MAX_STATS)

endmodule
